FILE: sv/byte_pattern_search_assert.svh
// ----------------------------------------------------------------------------
// byte_pattern_search_assert.svh
// Assertion macros shared by the byte pattern search modules.
// ----------------------------------------------------------------------------
`ifndef BYTE_PATTERN_SEARCH_ASSERT_SVH
`define BYTE_PATTERN_SEARCH_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: sv/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Types and register codes of the byte pattern search block.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_offset;
    logic        stream_done;
    logic [31:0] match_count;
  } out_item_t;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [4:0]  pattern_length;
  } cfg_t;

endpackage

FILE: sv/bps_matcher.sv
// ----------------------------------------------------------------------------
// bps_matcher
// Byte window, offset and match counters, and the pattern compare.
// ----------------------------------------------------------------------------
module bps_matcher
  import bps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_item_t res_item
);

`include "byte_pattern_search_assert.svh"

  localparam logic [4:0] MAX_LEN = 5'(MAX_PATTERN_BYTES);

  logic [7:0]             window_r   [MAX_PATTERN_BYTES];
  logic [7:0]             window_nxt [MAX_PATTERN_BYTES];
  logic [7:0]             pat        [16];
  logic [OFFSET_BITS-1:0] bytes_seen_r;
  logic [OFFSET_BITS-1:0] bytes_seen_nxt;
  logic [31:0]            found_total_r;
  logic [31:0]            found_total_nxt;
  logic [31:0]            found_inc;
  logic [4:0]             len;
  logic [4:0]             len_m1;
  logic [OFFSET_BITS-1:0] len_m1_wide;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS+31:0] start_wide;
  logic                   all_eq;
  logic                   hit;

  // Clamp the configured length into 1..MAX_PATTERN_BYTES.
  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      len = 5'd1;
    end else if (cfg.pattern_length > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = cfg.pattern_length;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pat[k]     = cfg.pattern_low[8*k +: 8];
      pat[k + 8] = cfg.pattern_high[8*k +: 8];
    end
  end

  // Shift the new byte in at the newest end.
  always_comb begin
    window_nxt[0] = in_item.data_byte;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      window_nxt[j] = window_r[j-1];
    end
  end

  // Window slot j holds the byte that must equal pattern byte len-1-j.
  always_comb begin
    logic [3:0] pidx;
    all_eq = 1'b1;
    pidx   = 4'd0;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      if (5'(j) < len) begin
        pidx = 4'(len - 5'(j) - 5'd1);
        if (window_nxt[j] != pat[pidx]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign len_m1      = len - 5'd1;
  assign len_m1_wide = {{(OFFSET_BITS-5){1'b0}}, len_m1};
  assign hit         = all_eq && (bytes_seen_r >= len_m1_wide);
  assign start       = bytes_seen_r - len_m1_wide;
  assign start_wide  = {32'd0, start};
  assign found_inc   = (hit && (found_total_r != '1)) ? found_total_r + 32'd1 : found_total_r;

  always_comb begin
    res_valid             = hit || in_item.end_of_stream;
    res_item.match_found  = hit;
    res_item.match_offset = hit ? start_wide[31:0] : 32'd0;
    res_item.stream_done  = in_item.end_of_stream;
    res_item.match_count  = found_inc;
  end

  // Clear the counters after the final byte; saturate the offset.
  always_comb begin
    if (in_item.end_of_stream) begin
      bytes_seen_nxt  = '0;
      found_total_nxt = '0;
    end else begin
      bytes_seen_nxt  = (bytes_seen_r == '1) ? bytes_seen_r : bytes_seen_r + 1'b1;
      found_total_nxt = found_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r  <= '0;
      found_total_r <= '0;
    end else if (in_fire) begin
      bytes_seen_r  <= bytes_seen_nxt;
      found_total_r <= found_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      window_r <= window_nxt;
    end
  end

  `BPS_ASSERT_NEXT(a_clear_on_last, clk, rst_n, in_fire && in_item.end_of_stream,
    bytes_seen_r == '0 && found_total_r == '0, "counters not cleared after last byte")
  `BPS_ASSERT_NEXT(a_hold_idle, clk, rst_n, !in_fire,
    $stable(bytes_seen_r) && $stable(found_total_r), "counters moved without a request")
  `BPS_ASSERT_IMPL(a_count_with_hit, clk, rst_n, hit, found_inc != 32'd0,
    "match seen but count is zero")

endmodule

FILE: sv/bps_out_buf.sv
// ----------------------------------------------------------------------------
// bps_out_buf
// Result register with a skid entry behind it.
// ----------------------------------------------------------------------------
module bps_out_buf
  import bps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

`include "byte_pattern_search_assert.svh"

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      skid_valid_r;
  out_item_t skid_data_r;
  logic      pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= push_item;
      end else begin
        skid_data_r <= push_item;
      end
    end
  end

  `BPS_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r,
    "skid entry holds a result while the output register is empty")
  `BPS_ASSERT_NEXT(a_skid_fill, clk, rst_n, push && out_valid_r && !pop, skid_valid_r,
    "stalled push did not land in the skid entry")
  `BPS_ASSERT_NEXT(a_skid_hold, clk, rst_n, skid_valid_r && !pop,
    skid_valid_r && $stable(skid_data_r), "skid entry lost while output stalled")

endmodule

FILE: sv/byte_pattern_search.sv
// ----------------------------------------------------------------------------
// byte_pattern_search
// Streaming byte pattern search with overlapping matches and saturating counts.
// ----------------------------------------------------------------------------
// Results: each is registered in the output register, or the skid entry if stalled.
// Throughput: one byte per cycle, set by the single compare between the input
//   port and result register; input stalls only while the skid entry is full.
// Reset: synchronous, active low; clears pattern registers (length to 1),
//   offset and match counters, and both result entries. No clearing pass.
// ----------------------------------------------------------------------------
module byte_pattern_search
  import bps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // byte stream in
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  // results out
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  // register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [63:0]               cfg_data
);

  cfg_t      cfg_r;
  logic      in_fire;
  logic      res_valid;
  out_item_t res_item;
  logic      buf_full;

  // Register writes are always taken; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.pattern_length <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    cfg_r.pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH:   cfg_r.pattern_high   <= cfg_data;
        CFG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Hold off new requests only while the skid entry is occupied; a request
  // can then always land in the output register or the skid entry.
  assign in_stall = buf_full;
  assign in_fire  = in_valid && !in_stall;

  // Advance the window and counters and form this byte's result.
  bps_matcher #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_matcher (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  // Drop bytes that give no result; register the rest toward the output.
  bps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && res_valid),
    .push_item (res_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: dv/byte_pattern_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_pattern_search_tb
// Self-checking bench for the streaming byte pattern search. A short table of
// hand-checked byte requests and register writes runs first. Random streams
// follow, with frequent pattern copies and near misses, under four idling
// phases. Every accepted byte is run through a local scan model, and each
// report from the block is compared field by field with the oldest report due.
// ----------------------------------------------------------------------------
module byte_pattern_search_tb;
  import bps_pkg::*;

  localparam int unsigned WIN_BYTES       = 16;
  localparam logic [31:0] SAT_MAX         = 32'hFFFF_FFFF;
  // A byte that reports nothing may still be in flight when the report queue
  // runs dry; waiting SETTLE_CYCLES lets it finish.
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned ITEMS_PER_PHASE = 425;
  localparam int unsigned NUM_PHASES      = 4;
  // Index 3 decodes to no register; writes to it must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  // Percent of cycles the sender idles / the receiver stalls, per phase.
  localparam int unsigned SENDER_IDLE [NUM_PHASES]    = '{0, 66, 0, 18};
  localparam int unsigned RECEIVER_STALL [NUM_PHASES] = '{0, 0, 66, 18};

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [63:0]               value;
    in_item_t                  req;
    bit                        typed;      // report typed in by hand
    bit                        has_report;
    out_item_t                 report;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT signals, inputs driven to known values from time zero
  // --------------------------------------------------------------------------
  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  in_item_t                  in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [63:0]               cfg_data  = '0;

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;

  // Scan model state: registers as written, window with index 0 newest,
  // offset of the next byte and hits so far in this stream.
  logic [63:0] pat_lo      = '0;
  logic [63:0] pat_hi      = '0;
  logic [4:0]  pat_len_reg = 5'd1;
  logic [7:0]  win [WIN_BYTES];
  logic [31:0] offset_next;
  logic [31:0] hits_in_stream;

  // Byte values the current pattern is built from; random streams draw on
  // them so that partial and full matches come often.
  logic [7:0]  alpha [4] = '{8'h41, 8'h42, 8'h00, 8'hFF};

  out_item_t   due_reports [$];
  dir_row_t    rows [$];
  out_item_t   want;

  byte_pattern_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle at the current phase rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Scan model
  // --------------------------------------------------------------------------
  // Clamp the length register: zero reads as one, anything above the window
  // depth reads as the full window.
  function automatic int unsigned active_len();
    if (pat_len_reg == 5'd0) return 1;
    if (pat_len_reg > WIN_BYTES) return WIN_BYTES;
    return 32'(pat_len_reg);
  endfunction

  function automatic logic [7:0] pattern_at(input int unsigned k);
    if (k < 8) return pat_lo[8*k +: 8];
    return pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic void clear_stream();
    foreach (win[i]) win[i] = 8'h00;
    offset_next    = '0;
    hits_in_stream = '0;
  endfunction

  function automatic void set_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                       input logic [63:0] value);
    case (idx)
      CFG_PATTERN_LOW:    pat_lo      = value;
      CFG_PATTERN_HIGH:   pat_hi      = value;
      CFG_PATTERN_LENGTH: pat_len_reg = value[4:0];
      default: ;
    endcase
  endfunction

  // Advance the window by one byte; return 1 when the byte owes a report.
  function automatic bit scan_byte(input in_item_t req, output out_item_t rep);
    int unsigned len;
    bit          hit;
    len = active_len();
    hit = 1'b0;
    rep = '0;
    for (int i = WIN_BYTES - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = req.data_byte;
    // Hold off until a full pattern length of this stream is in the window.
    if (offset_next >= len - 1) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (win[len-1-i] != pattern_at(i)) hit = 1'b0;
      end
      if (hit) begin
        rep.match_offset = offset_next - (len - 1);
        if (hits_in_stream != SAT_MAX) hits_in_stream++;
      end
    end
    // Offset saturates; later bytes all sit at the top offset.
    if (offset_next != SAT_MAX) offset_next++;
    rep.match_found = hit;
    rep.stream_done = req.end_of_stream;
    rep.match_count = hits_in_stream;
    if (req.end_of_stream) clear_stream();
    return hit || req.end_of_stream;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Send one byte request; called and returns at a falling edge. A typed
  // report replaces the model's, but the model still advances.
  task automatic send_byte(input in_item_t req, input bit typed,
                           input bit t_has, input out_item_t t_rep);
    out_item_t rep;
    bit        has;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    has = scan_byte(req, rep);
    if (typed) begin
      has = t_has;
      rep = t_rep;
    end
    if (has) due_reports = {due_reports, rep};
    sent_count++;
    @(negedge clk);
  endtask

  // Write a register only once the block has drained.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [63:0] value);
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    set_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Draw a new setting: pattern from a small alphabet, length at the
  // extremes or in range, plus writes to the unused index.
  task automatic pick_config();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) begin
      alpha[0] = 8'($urandom_range(255));
      alpha[1] = 8'($urandom_range(255));
      alpha[2] = 8'h00;
      alpha[3] = 8'hFF;
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = alpha[$urandom_range(3)];
        hi[8*k +: 8] = alpha[$urandom_range(3)];
      end
      if ($urandom_range(15) == 0) lo = '1;
      if ($urandom_range(15) == 0) hi = '1;
      if ($urandom_range(15) == 0) lo = {$urandom, $urandom};
      write_register(CFG_PATTERN_LOW, lo);
      write_register(CFG_PATTERN_HIGH, hi);
    end
    if (pick != 6) begin
      len_word = {$urandom, $urandom};
      case ($urandom_range(7))
        0:       len_word[4:0] = 5'd1;
        1:       len_word[4:0] = 5'd16;
        2:       len_word[4:0] = 5'd0;
        3:       len_word[4:0] = 5'd31;
        4:       len_word[4:0] = 5'd17;
        default: len_word[4:0] = 5'($urandom_range(1, 16));
      endcase
      write_register(CFG_PATTERN_LENGTH, len_word);
    end
    if (pick >= 8) write_register(CFG_UNUSED, {$urandom, $urandom});
  endtask

  // Send a run of bytes: pattern copies (some with one bit flipped),
  // alphabet bytes and noise. Most runs end the stream; the rest carry on
  // into the next run so that a setting changes mid-stream.
  task automatic send_segment();
    logic [7:0]  seg [$];
    int unsigned n;
    int unsigned len;
    int unsigned pick;
    bit          eos_end;
    in_item_t    req;
    n   = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40);
    len = active_len();
    while (seg.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        for (int j = 0; j < len; j++) seg = {seg, pattern_at(j)};
        if ($urandom_range(3) == 0)
          seg[seg.size() - 1 - $urandom_range(len - 1)] ^= 8'h01 << $urandom_range(7);
      end else if (pick < 80) begin
        seg = {seg, alpha[$urandom_range(3)]};
      end else begin
        seg = {seg, 8'($urandom_range(255))};
      end
    end
    eos_end = ($urandom_range(9) < 7);
    foreach (seg[i]) begin
      req.data_byte     = seg[i];
      req.end_of_stream = (eos_end && i == seg.size() - 1) || ($urandom_range(49) == 0);
      send_byte(req, 1'b0, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Report checker
  // --------------------------------------------------------------------------
  task automatic report_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_reports.size() == 0) begin
        $error("report with none due: %p", out_data);
        fail_count++;
      end else begin
        want = due_reports.pop_front();
        report_field("match_found", want.match_found, out_data.match_found);
        report_field("match_offset", want.match_offset, out_data.match_offset);
        report_field("stream_done", want.stream_done, out_data.stream_done);
        report_field("match_count", want.match_count, out_data.match_count);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void add_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [63:0] value);
    dir_row_t r;
    r       = '{kind: ROW_CFG, default: '0};
    r.idx   = idx;
    r.value = value;
    rows    = {rows, r};
  endfunction

  function automatic void add_row(input logic [7:0] data, input bit eos, input bit typed,
                                  input bit has, input bit found, input logic [31:0] offset,
                                  input bit done, input logic [31:0] count);
    dir_row_t r;
    r                     = '{kind: ROW_BYTE, default: '0};
    r.req.data_byte       = data;
    r.req.end_of_stream   = eos;
    r.typed               = typed;
    r.has_report          = has;
    r.report.match_found  = found;
    r.report.match_offset = offset;
    r.report.stream_done  = done;
    r.report.match_count  = count;
    rows                  = {rows, r};
  endfunction

  initial begin : stimulus
    int unsigned phase_goal;
    clear_stream();

    // Unused index first: must leave the reset pattern (one zero byte) alone.
    add_cfg(CFG_UNUSED, '1);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 32'd1);
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0, 1'b1, 32'd1);
    // Length zero reads as one; only the first pattern byte counts.
    add_cfg(CFG_PATTERN_LENGTH, 64'd0);
    add_cfg(CFG_PATTERN_LOW, 64'hA5A5_A5A5_A5A5_A5FF);
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0, 1'b1, 32'd1);
    // Zeros left in the cleared window must not match at stream start;
    // then overlapping hits.
    add_cfg(CFG_PATTERN_LENGTH, 64'd2);
    add_cfg(CFG_PATTERN_LOW, 64'd0);
    add_cfg(CFG_PATTERN_HIGH, '1);
    add_row(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0, 32'd0);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 32'd1);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd1, 1'b0, 32'd2);
    add_row(8'h7F, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0, 1'b1, 32'd2);
    // All-ones length word reads as 31, clamped to the full 16 bytes.
    add_cfg(CFG_PATTERN_LENGTH, '1);
    add_cfg(CFG_PATTERN_LOW, 64'h0706_0504_0302_0100);
    add_cfg(CFG_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908);
    for (int b = 0; b < 15; b++) add_row(8'(b), 1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
    add_row(8'h0F, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0, 1'b1, 32'd1);
    // Change the setting, then again mid-stream; the window carries over.
    add_cfg(CFG_PATTERN_LENGTH, 64'd1);
    add_cfg(CFG_PATTERN_LOW, 64'h41);
    add_row(8'h41, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 32'd1);
    add_cfg(CFG_PATTERN_LENGTH, 64'd2);
    add_cfg(CFG_PATTERN_LOW, 64'h4241);
    add_row(8'h42, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 32'd2);
    add_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0, 1'b1, 32'd2);

    // Hold reset, then release it on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_register(rows[i].idx, rows[i].value);
      else send_byte(rows[i].req, rows[i].typed, rows[i].has_report, rows[i].report);
    end

    // Random streams, one idling mix per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct   = SENDER_IDLE[p];
      stall_pct  = RECEIVER_STALL[p];
      phase_goal = sent_count + ITEMS_PER_PHASE;
      while (sent_count < phase_goal) begin
        pick_config();
        send_segment();
      end
    end

    // Drop valid, drain the reports still due, then let the pipe settle.
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
